### src/frame_sequence_crossfade_defines.svh
// Assertion helpers shared by the crossfade RTL.
`ifndef FRAME_SEQUENCE_CROSSFADE_DEFINES_SVH
`define FRAME_SEQUENCE_CROSSFADE_DEFINES_SVH

// Same-cycle implication.
`define FSC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/fsc_pkg.sv
package fsc_pkg;

   localparam int RateW    = 16;
   localparam int ModeW    = 2;
   localparam int FrameW   = 8;
   localparam int ChanW    = 8;
   localparam int WeightW  = 17;
   localparam int KindW    = 2;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam int NumChan  = 3;
   localparam int FracW    = 16;

   // restoring divider: dividend is (count+1)<<16 plus half the rate
   localparam int DivNumW  = 2 * RateW;
   localparam int DivCntW  = $clog2(DivNumW);
   localparam int ChIdxW   = $clog2(NumChan);

   localparam logic [WeightW-1:0] WeightOne = {1'b1, {(WeightW-1){1'b0}}};
   // 0.5 in Q16 for round-half-up on the blend
   localparam int MixAccW = FracW + ChanW + 4;
   localparam logic [MixAccW-1:0] RoundHalf = MixAccW'(1) << (FracW - 1);

   localparam logic [KindW-1:0] KindTick    = 2'd0;
   localparam logic [KindW-1:0] KindPixel   = 2'd1;
   localparam logic [KindW-1:0] KindRestart = 2'd2;

   localparam logic [ModeW-1:0] ModeStatic = 2'd0;
   localparam logic [ModeW-1:0] ModeOnce   = 2'd1;
   localparam logic [ModeW-1:0] ModeLoop   = 2'd2;
   localparam logic [ModeW-1:0] ModeBounce = 2'd3;

   localparam logic [CsrIdxW-1:0] CsrChangeRate   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrSequenceMode = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrFrameCount   = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrBlendEnable  = 2'd3;

   localparam logic [RateW-1:0]  RateReset      = 16'd100;
   localparam logic [ModeW-1:0]  ModeReset      = ModeLoop;
   localparam logic [FrameW-1:0] CountReset     = 8'd1;
   localparam logic              BlendReset     = 1'b1;
   localparam logic [RateW-1:0]  CountdownReset = 16'd100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MIX,
      ST_SEND
   } fsc_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fsc_unit_status_type;

   typedef logic [NumChan-1:0][ChanW-1:0] fsc_rgb_type;

   // blend target for the current index and direction
   function automatic logic [FrameW-1:0] target_frame(
      input logic [ModeW-1:0]  mode,
      input logic [FrameW-1:0] cnt,
      input logic [FrameW-1:0] cur,
      input logic              fwd
   );
      logic [FrameW:0] nxt;
      nxt = {1'b0, cur} + (FrameW+1)'(1);
      if (mode == ModeStatic || cnt == FrameW'(1)) return cur;
      if (fwd) begin
         if (nxt < {1'b0, cnt}) return nxt[FrameW-1:0];
         if (mode == ModeOnce) return cur;
         if (mode == ModeLoop) return '0;
         return cur - FrameW'(1);
      end
      return (cur != '0) ? cur - FrameW'(1) : FrameW'(1);
   endfunction

endpackage

### src/fsc_ifs.sv
interface fsc_req_if;
   import fsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [KindW-1:0]  kind;
   logic [ChanW-1:0]  last_red;
   logic [ChanW-1:0]  last_green;
   logic [ChanW-1:0]  last_blue;
   logic [ChanW-1:0]  next_red;
   logic [ChanW-1:0]  next_green;
   logic [ChanW-1:0]  next_blue;
   logic [FrameW-1:0] start_frame;

   modport source (output valid, kind, last_red, last_green, last_blue,
                   next_red, next_green, next_blue, start_frame, input ready);
   modport sink   (input valid, kind, last_red, last_green, last_blue,
                   next_red, next_green, next_blue, start_frame, output ready);
endinterface

interface fsc_rsp_if;
   import fsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [ChanW-1:0]  out_red;
   logic [ChanW-1:0]  out_green;
   logic [ChanW-1:0]  out_blue;
   logic              load_request;
   logic              finished;
   logic [FrameW-1:0] frame_now;
   logic [FrameW-1:0] frame_following;

   modport source (output valid, out_red, out_green, out_blue, load_request,
                   finished, frame_now, frame_following, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, load_request,
                   finished, frame_now, frame_following, output ready);
endinterface

interface fsc_csr_if;
   import fsc_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/frame_sequence_crossfade.sv
// Restart, non-expiring tick without blend, expiring tick, pass-through pixel
// and unknown kinds: result valid in the cycle after the input beat.
// Tick that latches a weight: goes through the 32-step restoring divider first.
// Blended pixel: one channel per cycle through the shared multiplier.
// One item at a time; the next beat is taken the cycle after the result beat.
// Synchronous active-high reset loads register defaults and the sequence state.
`include "frame_sequence_crossfade_defines.svh"

module frame_sequence_crossfade (
   input logic       clock,
   input logic       reset,
   fsc_req_if.sink   req_bus,
   fsc_rsp_if.source rsp_bus,
   fsc_csr_if.sink   csr_bus
);
   import fsc_pkg::*;

   fsc_state_type      state_ff, state_in;

   logic [RateW-1:0]   change_rate_ff;
   logic [ModeW-1:0]   sequence_mode_ff;
   logic [FrameW-1:0]  frame_count_ff;
   logic               blend_enable_ff;

   logic [RateW-1:0]   countdown_ff, countdown_in;
   logic [FrameW-1:0]  frame_index_ff, frame_index_in;
   logic               going_forward_ff, going_forward_in;
   logic               blend_active_ff, blend_active_in;
   logic [WeightW-1:0] blend_weight_ff, blend_weight_in;

   fsc_rgb_type        rgb_ff, rgb_in;
   logic               load_ff, load_in;
   logic               fin_ff, fin_in;
   fsc_rgb_type        pix_last_ff, pix_last_in;
   fsc_rgb_type        pix_next_ff, pix_next_in;

   logic               req_fire;
   logic               is_tick;
   logic               is_pixel;
   logic               frozen;
   logic               expired;
   logic               need_div;
   logic               need_mix;
   logic               div_start;
   logic               mix_start;
   logic [FrameW-1:0]  cnt_eff;
   logic [RateW-1:0]   cdec;
   logic [RateW-1:0]   cdec_p1;
   logic               fwd_eff;
   logic [FrameW:0]    nxt9;
   logic [FrameW-1:0]  bwd;
   logic               at_end;
   logic [DivNumW-1:0] dividend;

   fsc_unit_status_type div_status;
   fsc_unit_status_type mix_status;
   logic [WeightW-1:0]  quotient;
   fsc_rgb_type         mix_result;

   // ---------------- decode ----------------
   always_comb begin
      req_fire = req_bus.valid && req_bus.ready;
      is_tick  = req_bus.kind == KindTick;
      is_pixel = req_bus.kind == KindPixel;
      cnt_eff  = (frame_count_ff == '0) ? FrameW'(1) : frame_count_ff;
      frozen   = (change_rate_ff == '0) || (sequence_mode_ff == ModeStatic) ||
                 (cnt_eff == FrameW'(1));
      cdec     = (countdown_ff == '0) ? '0 : countdown_ff - RateW'(1);
      cdec_p1  = cdec + RateW'(1);
      expired  = cdec == '0;
      fwd_eff  = (sequence_mode_ff != ModeBounce) ? 1'b1 : going_forward_ff;
      nxt9     = {1'b0, frame_index_ff} + (FrameW+1)'(1);
      bwd      = frame_index_ff - FrameW'(1);
      at_end   = nxt9 >= {1'b0, cnt_eff};
      need_div = is_tick && !frozen && !expired && blend_enable_ff;
      need_mix = is_pixel && blend_active_ff;
      dividend = {cdec_p1, {FracW{1'b0}}} + DivNumW'(change_rate_ff[RateW-1:1]);
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (need_div)      state_in = ST_DIV;
               else if (need_mix) state_in = ST_MIX;
               else               state_in = ST_SEND;
            end
         end
         ST_DIV:  if (div_status.done) state_in = ST_SEND;
         ST_MIX:  if (mix_status.done) state_in = ST_SEND;
         ST_SEND: if (rsp_bus.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- FSM outputs ----------------
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      div_start     = 1'b0;
      mix_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            div_start     = req_bus.valid && need_div;
            mix_start     = req_bus.valid && need_mix;
         end
         ST_SEND: rsp_bus.valid = 1'b1;
         default: ;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      countdown_in     = countdown_ff;
      frame_index_in   = frame_index_ff;
      going_forward_in = going_forward_ff;
      blend_active_in  = blend_active_ff;
      blend_weight_in  = blend_weight_ff;
      rgb_in           = rgb_ff;
      load_in          = load_ff;
      fin_in           = fin_ff;
      pix_last_in      = pix_last_ff;
      pix_next_in      = pix_next_ff;

      if (state_ff == ST_IDLE && req_fire) begin
         rgb_in  = '0;
         load_in = 1'b0;
         fin_in  = 1'b0;
         case (req_bus.kind)
            KindTick: begin
               if (!frozen) begin
                  countdown_in = cdec;
                  if (expired) begin
                     going_forward_in = fwd_eff;
                     if (fwd_eff && at_end && sequence_mode_ff == ModeOnce) begin
                        // index stays put and countdown holds at zero; every later tick finishes too
                        fin_in = 1'b1;
                     end else begin
                        if (fwd_eff) begin
                           if (!at_end) begin
                              frame_index_in = nxt9[FrameW-1:0];
                           end else if (sequence_mode_ff == ModeLoop) begin
                              frame_index_in = '0;
                           end else begin
                              frame_index_in   = cnt_eff - FrameW'(2);
                              going_forward_in = 1'b0;
                           end
                        end else if (frame_index_ff == '0) begin
                           frame_index_in   = FrameW'(1);
                           going_forward_in = 1'b1;
                        end else begin
                           frame_index_in = (bwd >= cnt_eff) ? cnt_eff - FrameW'(1) : bwd;
                        end
                        countdown_in    = change_rate_ff;
                        blend_active_in = 1'b0;
                        load_in         = 1'b1;
                     end
                  end
               end
            end
            KindPixel: begin
               pix_last_in = {req_bus.last_blue, req_bus.last_green, req_bus.last_red};
               pix_next_in = {req_bus.next_blue, req_bus.next_green, req_bus.next_red};
               if (!blend_active_ff) rgb_in = pix_last_in;
            end
            KindRestart: begin
               frame_index_in   = req_bus.start_frame;
               countdown_in     = change_rate_ff;
               going_forward_in = 1'b1;
               blend_active_in  = 1'b0;
            end
            default: ;
         endcase
      end

      if (state_ff == ST_DIV && div_status.done) begin
         blend_weight_in = quotient;
         blend_active_in = 1'b1;
      end
      if (state_ff == ST_MIX && mix_status.done) rgb_in = mix_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         change_rate_ff   <= RateReset;
         sequence_mode_ff <= ModeReset;
         frame_count_ff   <= CountReset;
         blend_enable_ff  <= BlendReset;
         countdown_ff     <= CountdownReset;
         frame_index_ff   <= '0;
         going_forward_ff <= 1'b1;
         blend_active_ff  <= 1'b0;
         blend_weight_ff  <= '0;
      end else begin
         state_ff         <= state_in;
         countdown_ff     <= countdown_in;
         frame_index_ff   <= frame_index_in;
         going_forward_ff <= going_forward_in;
         blend_active_ff  <= blend_active_in;
         blend_weight_ff  <= blend_weight_in;
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CsrChangeRate:   change_rate_ff   <= csr_bus.data[RateW-1:0];
               CsrSequenceMode: sequence_mode_ff <= csr_bus.data[ModeW-1:0];
               CsrFrameCount:   frame_count_ff   <= csr_bus.data[FrameW-1:0];
               CsrBlendEnable:  blend_enable_ff  <= csr_bus.data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rgb_ff      <= rgb_in;
      load_ff     <= load_in;
      fin_ff      <= fin_in;
      pix_last_ff <= pix_last_in;
      pix_next_ff <= pix_next_in;
   end

   assign csr_bus.ready = 1'b1;

   fsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (change_rate_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   fsc_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .start   (mix_start),
      .weight  (blend_weight_ff),
      .last_px (pix_last_ff),
      .next_px (pix_next_ff),
      .status  (mix_status),
      .result  (mix_result)
   );

   assign rsp_bus.out_red         = rgb_ff[0];
   assign rsp_bus.out_green       = rgb_ff[1];
   assign rsp_bus.out_blue        = rgb_ff[2];
   assign rsp_bus.load_request    = load_ff;
   assign rsp_bus.finished        = fin_ff;
   assign rsp_bus.frame_now       = frame_index_ff;
   assign rsp_bus.frame_following = target_frame(sequence_mode_ff, cnt_eff,
                                                 frame_index_ff, going_forward_ff);

   `FSC_ASSERT_IMPLY(a_rsp_blocks_req, clock, reset, rsp_bus.valid, !req_bus.ready, "request taken while result pending")
   `FSC_ASSERT_NEXT(a_blend_pixel_mixes, clock, reset, req_fire && is_pixel && blend_active_ff, state_ff == ST_MIX && mix_status.busy, "blended pixel did not start mixer")
   `FSC_ASSERT_IMPLY(a_load_fin_excl, clock, reset, rsp_bus.valid, !(load_ff && fin_ff), "load and finished both set")
   `FSC_ASSERT_NEXT(a_div_sets_weight, clock, reset, state_ff == ST_DIV && div_status.done, state_ff == ST_SEND && blend_active_ff, "weight not latched after divide")
   `FSC_ASSERT_IMPLY(a_div_busy_in_div, clock, reset, div_status.busy, state_ff == ST_DIV, "divider busy outside divide")

endmodule

### src/fsc_div.sv
module fsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fsc_pkg::DivNumW-1:0]       dividend,
   input  logic [fsc_pkg::RateW-1:0]         divisor,
   output fsc_pkg::fsc_unit_status_type      status,
   output logic [fsc_pkg::WeightW-1:0]       quotient
);
   import fsc_pkg::*;

   localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivNumW - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivNumW-1:0]  num_ff, num_in;
   logic [RateW-1:0]    rem_ff, rem_in;
   logic [WeightW-1:0]  quo_ff, quo_in;
   logic                ovf_ff, ovf_in;
   logic [DivCntW-1:0]  cnt_ff, cnt_in;

   logic [RateW:0]      trial;
   logic [RateW:0]      diff;
   logic                ge;
   logic                sat;

   always_comb begin
      trial = {rem_ff, num_ff[DivNumW-1]};
      diff  = trial - {1'b0, divisor};
      ge    = trial >= {1'b0, divisor};

      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == LastStep);
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         num_in  = dividend;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = ge ? diff[RateW-1:0] : trial[RateW-1:0];
         // quotient bits above the Q16 range only mark saturation
         ovf_in = ovf_ff | quo_ff[WeightW-1];
         quo_in = {quo_ff[WeightW-2:0], ge};
         cnt_in = cnt_ff + DivCntW'(1);
         if (cnt_ff == LastStep) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

   assign sat         = ovf_ff | (quo_ff[WeightW-1] & (|quo_ff[WeightW-2:0]));
   assign quotient    = sat ? WeightOne : quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### src/fsc_mix.sv
module fsc_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fsc_pkg::WeightW-1:0]   weight,
   input  fsc_pkg::fsc_rgb_type          last_px,
   input  fsc_pkg::fsc_rgb_type          next_px,
   output fsc_pkg::fsc_unit_status_type  status,
   output fsc_pkg::fsc_rgb_type          result
);
   import fsc_pkg::*;

   localparam logic [ChIdxW-1:0] LastCh = ChIdxW'(NumChan - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ChIdxW-1:0]   ch_ff, ch_in;
   fsc_rgb_type         res_ff;

   logic [ChanW-1:0]              lval;
   logic [ChanW-1:0]              nval;
   logic signed [ChanW:0]         diff;
   logic signed [WeightW:0]       wsg;
   logic signed [ChanW+WeightW:0] prod;
   logic signed [MixAccW-1:0]     acc;

   // last*w + next*(1-w) = next + (last-next)*w, one channel per cycle
   always_comb begin
      lval = last_px[ch_ff];
      nval = next_px[ch_ff];
      diff = $signed({1'b0, lval}) - $signed({1'b0, nval});
      wsg  = $signed({1'b0, weight});
      prod = diff * wsg;
      acc  = $signed({4'b0, nval, {FracW{1'b0}}}) + MixAccW'(prod) + $signed(RoundHalf);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = busy_ff && (ch_ff == LastCh);
      ch_in   = ch_ff;
      if (start) begin
         busy_in = 1'b1;
         ch_in   = '0;
      end else if (busy_ff) begin
         ch_in = ch_ff + ChIdxW'(1);
         if (ch_ff == LastCh) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      if (busy_ff) res_ff[ch_ff] <= acc[FracW+ChanW-1:FracW];
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = res_ff;

endmodule
